/* rtl/gwve_pkg.sv */
// Package for the GPS wind velocity estimator: shared constants, widths and
// the arctangent table used by the CORDIC unit. No dependencies.
`timescale 1ns / 1ps

package gwve_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CNT_W = 6;
  localparam int MUL_B_W = 33;
  localparam int DIV_N_W = 48;
  localparam int DIV_D_W = 17;
  localparam int SQRT_STEPS = 32;

  localparam logic CFG_MIN_GAP = 1'b0;
  localparam logic CFG_MAX_GAP = 1'b1;

  localparam logic [15:0] MIN_GAP_RST = 16'd400;
  localparam logic [15:0] MAX_GAP_RST = 16'd30000;

  localparam logic signed [33:0] DEG90_E7 = 34'sd900000000;
  localparam logic signed [33:0] DEG180_E7 = 34'sd1800000000;
  localparam logic signed [34:0] DEG180_W = 35'sd1800000000;
  localparam logic signed [34:0] DEG360_W = 35'sd3600000000;
  localparam logic signed [63:0] INV_GAIN_Q30 = 64'sd652032874;
  localparam logic signed [63:0] COS_ONE_W = 64'sd1073741824;
  localparam logic [30:0] COS_ONE = 31'h40000000;
  localparam logic [31:0] COS_RND = 32'd8192;
  localparam logic [MUL_B_W-1:0] MM_PER_E7DEG = 33'd11132;
  localparam logic [DIV_N_W-1:0] VEL_MAX = 48'd2147483647;
  localparam logic [DIV_N_W-1:0] SPD_MAX = 48'd65535;
  localparam logic [DIV_N_W-1:0] SPD_RND = 48'd5;
  localparam logic [DIV_D_W-1:0] SPD_DIV = 17'd10;
  localparam logic [DIV_N_W-1:0] DIR_RND = 48'd50000;
  localparam logic [DIV_D_W-1:0] DIR_DIV = 17'd100000;
  localparam logic [DIV_N_W-1:0] DIR_FULL = 48'd36000;

  function automatic logic [29:0] atan_e7(input logic [4:0] k);
    logic [29:0] v;
    unique case (k)
      5'd0: v = 30'd450000000;
      5'd1: v = 30'd265650512;
      5'd2: v = 30'd140362435;
      5'd3: v = 30'd71250163;
      5'd4: v = 30'd35763344;
      5'd5: v = 30'd17899106;
      5'd6: v = 30'd8951737;
      5'd7: v = 30'd4476142;
      5'd8: v = 30'd2238105;
      5'd9: v = 30'd1119057;
      5'd10: v = 30'd559529;
      5'd11: v = 30'd279765;
      5'd12: v = 30'd139882;
      5'd13: v = 30'd69941;
      5'd14: v = 30'd34971;
      5'd15: v = 30'd17485;
      5'd16: v = 30'd8743;
      5'd17: v = 30'd4371;
      5'd18: v = 30'd2186;
      5'd19: v = 30'd1093;
      5'd20: v = 30'd546;
      5'd21: v = 30'd273;
      5'd22: v = 30'd137;
      5'd23: v = 30'd68;
      5'd24: v = 30'd34;
      5'd25: v = 30'd17;
      5'd26: v = 30'd9;
      5'd27: v = 30'd4;
      5'd28: v = 30'd2;
      5'd29: v = 30'd1;
      5'd30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/gwve_mul.sv */
// Shift-and-add multiplier that consumes one multiplier bit per cycle.
// Depends on gwve_pkg.
`timescale 1ns / 1ps

module gwve_mul import gwve_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [63:0]        a_in,
  input  logic [MUL_B_W-1:0] b_in,
  output logic               done,
  output logic [63:0]        prod
);

  logic [63:0] a_r, acc_r, acc_nxt;
  logic [MUL_B_W-1:0] b_r;
  logic [CNT_W-1:0] cnt_r;
  logic busy_r, done_r;

  assign acc_nxt = b_r[0] ? acc_r + a_r : acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MUL_B_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a_in;
      b_r <= b_in;
      acc_r <= '0;
    end else if (busy_r) begin
      a_r <= {a_r[62:0], 1'b0};
      b_r <= {1'b0, b_r[MUL_B_W-1:1]};
      acc_r <= acc_nxt;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

/* rtl/gwve_div.sv */
// Restoring divider that produces one quotient bit per cycle.
// Depends on gwve_pkg.
`timescale 1ns / 1ps

module gwve_div import gwve_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DIV_N_W-1:0] num,
  input  logic [DIV_D_W-1:0] den,
  output logic               done,
  output logic [DIV_N_W-1:0] quo
);

  logic [DIV_D_W-1:0] den_r, rem_r, rem_nxt;
  logic [DIV_N_W-1:0] quo_r;
  logic [DIV_D_W:0] rem_sh, rem_dif;
  logic ge;
  logic [CNT_W-1:0] cnt_r;
  logic busy_r, done_r;

  always_comb begin
    rem_sh = {rem_r, quo_r[DIV_N_W-1]};
    rem_dif = rem_sh - {1'b0, den_r};
    ge = rem_sh >= {1'b0, den_r};
    rem_nxt = ge ? rem_dif[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_N_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem_r <= '0;
      quo_r <= num;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DIV_N_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo = quo_r;

endmodule

/* rtl/gwve_sqrt.sv */
// Digit-by-digit integer square root, two radicand bits per cycle.
// Depends on gwve_pkg.
`timescale 1ns / 1ps

module gwve_sqrt import gwve_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] rad,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] rad_r;
  logic [31:0] root_r;
  logic [34:0] rem_r;
  logic [36:0] rem_sh, trial, rem_dif;
  logic ge;
  logic [CNT_W-1:0] cnt_r;
  logic busy_r, done_r;

  always_comb begin
    rem_sh = {rem_r, rad_r[63:62]};
    trial = {3'b000, root_r, 2'b01};
    rem_dif = rem_sh - trial;
    ge = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SQRT_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r <= rad;
      root_r <= '0;
      rem_r <= '0;
    end else if (busy_r) begin
      rad_r <= {rad_r[61:0], 2'b00};
      root_r <= {root_r[30:0], ge};
      rem_r <= ge ? rem_dif[34:0] : rem_sh[34:0];
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

/* rtl/gwve_cordic.sv */
// Iterative CORDIC, one micro-rotation per cycle, in rotation mode for the
// cosine and in vectoring mode for the bearing. Depends on gwve_pkg.
`timescale 1ns / 1ps

module gwve_cordic import gwve_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               vec,
  input  logic signed [63:0] x0,
  input  logic signed [63:0] y0,
  input  logic signed [33:0] z0,
  output logic               done,
  output logic signed [63:0] x_out,
  output logic signed [33:0] z_out
);

  logic signed [63:0] x_r, y_r, x_nxt, y_nxt, xs, ys;
  logic signed [33:0] z_r, z_nxt, at;
  logic vec_r, s_neg;
  logic [CNT_W-1:0] cnt_r;
  logic busy_r, done_r;

  always_comb begin
    xs = x_r >>> cnt_r[4:0];
    ys = y_r >>> cnt_r[4:0];
    at = $signed({4'b0000, atan_e7(cnt_r[4:0])});
    s_neg = vec_r ? (y_r > 64'sd0) : z_r[33];
    if (s_neg) begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + at;
    end else begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      vec_r <= vec;
      x_r <= x0;
      y_r <= y0;
      z_r <= z0;
    end else if (busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign done = done_r;
  assign x_out = x_r;
  assign z_out = z_r;

endmodule

/* rtl/gps_wind_velocity_estimator.sv */
// Top level of the GPS wind velocity estimator: sequencer, state and ports.
// Depends on gwve_pkg, gwve_mul, gwve_div, gwve_sqrt and gwve_cordic.
`timescale 1ns / 1ps

// The block takes one GPS report per request and returns one result for
// each. A report that updates the estimate has its result valid only after
// the bit-serial multiplier (five products), the bit-serial divider (four
// quotients), the square root and two CORDIC passes have run in turn; the
// bearing pass is skipped when the smoothed velocity is zero. Each unit's
// start and done handshakes are registered. A report without an update goes
// straight from the check to the output. Only one report is worked on at a
// time; the next one is taken while the previous result still waits on the
// output.

module gps_wind_velocity_estimator import gwve_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // lat_e7[30:0], lon_e7[62:31], rx_time_ms[94:63]
  input  logic        in_tuser,   // gps_fix
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // speed_cmps[15:0], wind_dir_cdeg[31:16]
  output logic        out_tuser,  // wind_valid
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE, S_CHK, S_COS, S_MN, S_DN, S_ME1, S_ME2, S_DE, S_EMA, S_SQE,
    S_SQN, S_SQR, S_CM, S_BRG, S_WST, S_WD, S_FIN
  } state_t;

  state_t state_r;
  logic [15:0] min_gap_r, max_gap_r;
  logic signed [30:0] lat_r;
  logic signed [31:0] lon_r, prev_lat_r, prev_lon_r;
  logic [31:0] time_r, prev_time_r;
  logic fix_r, have_prev_r, seeded_r;
  logic signed [31:0] ema_e_r, ema_n_r, vn_r;
  logic [31:0] dlat_mag_r, dlon_mag_r;
  logic dlat_neg_r, dlon_neg_r, zero_vec_r;
  logic [15:0] gap_r;
  logic [16:0] cq16_r;
  logic [63:0] sq_r;
  logic signed [33:0] bear_r;
  logic [15:0] res_speed_r, res_dir_r, out_speed_r, out_dir_r;
  logic res_valid_r, out_valid_r, out_tvalid_r;

  logic mul_start_r, div_start_r, sqrt_start_r, cor_start_r, cor_vec_r;
  logic [63:0] mul_a_r;
  logic [MUL_B_W-1:0] mul_b_r;
  logic [DIV_N_W-1:0] div_num_r;
  logic [DIV_D_W-1:0] div_den_r;
  logic [63:0] sqrt_rad_r;
  logic signed [63:0] cor_x0_r, cor_y0_r;
  logic signed [33:0] cor_z0_r;

  logic mul_done, div_done, sqrt_done, cor_done;
  logic [63:0] mul_prod;
  logic [DIV_N_W-1:0] div_quo;
  logic [31:0] sqrt_root;
  logic signed [63:0] cor_x;
  logic signed [33:0] cor_z;

  logic [31:0] gap;
  logic upd;
  logic signed [32:0] lat_sum, lat_adj, lat_half, dlat, dlon;
  logic signed [33:0] mean, lat_half_w;
  logic [32:0] dlat_abs, dlon_abs;
  logic [30:0] xc;
  logic [31:0] cq_sum;
  logic signed [31:0] ve, ema_e_nxt, ema_n_nxt;
  logic [31:0] ema_e_abs, ema_n_abs;
  logic signed [34:0] w1, wmod;
  logic signed [63:0] vx0, vy0;
  logic mul_go, div_go, sqrt_go, cor_go;

  function automatic logic signed [31:0] vel_of(input logic [DIV_N_W-1:0] q,
                                                input logic neg);
    logic [30:0] m;
    m = (q > VEL_MAX) ? 31'h7fffffff : q[30:0];
    return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  function automatic logic signed [31:0] avg_of(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    logic signed [32:0] s, t;
    s = {a[31], a} + {b[31], b};
    t = s + $signed({32'b0, s[32]});
    return t[32:1];
  endfunction

  always_comb begin
    gap = time_r - prev_time_r;
    upd = fix_r && have_prev_r && (gap > {16'b0, min_gap_r}) && (gap < {16'b0, max_gap_r});
    lat_sum = $signed({{2{lat_r[30]}}, lat_r}) + $signed({prev_lat_r[31], prev_lat_r});
    lat_adj = lat_sum + $signed({32'b0, lat_sum[32]});
    lat_half = lat_adj >>> 1;
    lat_half_w = {lat_half[32], lat_half};
    if (lat_half_w > DEG90_E7) begin
      mean = DEG90_E7;
    end else if (lat_half_w < -DEG90_E7) begin
      mean = -DEG90_E7;
    end else begin
      mean = lat_half_w;
    end
    dlat = $signed({{2{lat_r[30]}}, lat_r}) - $signed({prev_lat_r[31], prev_lat_r});
    dlon = $signed({lon_r[31], lon_r}) - $signed({prev_lon_r[31], prev_lon_r});
    dlat_abs = dlat[32] ? 33'(-dlat) : 33'(dlat);
    dlon_abs = dlon[32] ? 33'(-dlon) : 33'(dlon);
    if (cor_x[63]) begin
      xc = '0;
    end else if (cor_x > COS_ONE_W) begin
      xc = COS_ONE;
    end else begin
      xc = cor_x[30:0];
    end
    cq_sum = {1'b0, xc} + COS_RND;
    ve = vel_of(div_quo, dlon_neg_r);
    ema_e_nxt = seeded_r ? avg_of(ve, ema_e_r) : ve;
    ema_n_nxt = seeded_r ? avg_of(vn_r, ema_n_r) : vn_r;
    ema_e_abs = ema_e_r[31] ? 32'(-ema_e_r) : 32'(ema_e_r);
    ema_n_abs = ema_n_r[31] ? 32'(-ema_n_r) : 32'(ema_n_r);
    vx0 = $signed({{4{ema_n_r[31]}}, ema_n_r, 28'b0});
    vy0 = $signed({{4{ema_e_r[31]}}, ema_e_r, 28'b0});
    w1 = $signed({bear_r[33], bear_r}) + DEG180_W;
    wmod = (w1 >= DEG360_W) ? w1 - DEG360_W : w1;
    mul_go = ((state_r == S_COS) && cor_done) || ((state_r == S_DN) && div_done) ||
             ((state_r == S_ME1) && mul_done) || (state_r == S_EMA) ||
             ((state_r == S_SQE) && mul_done);
    div_go = ((state_r == S_MN) && mul_done) || ((state_r == S_ME2) && mul_done) ||
             ((state_r == S_SQR) && sqrt_done) || (state_r == S_WST);
    sqrt_go = (state_r == S_SQN) && mul_done;
    cor_go = ((state_r == S_CHK) && upd) ||
             ((state_r == S_CM) && div_done && !zero_vec_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      min_gap_r <= MIN_GAP_RST;
      max_gap_r <= MAX_GAP_RST;
      have_prev_r <= 1'b0;
      seeded_r <= 1'b0;
      prev_lat_r <= '0;
      prev_lon_r <= '0;
      prev_time_r <= '0;
      ema_e_r <= '0;
      ema_n_r <= '0;
      out_tvalid_r <= 1'b0;
      mul_start_r <= 1'b0;
      div_start_r <= 1'b0;
      sqrt_start_r <= 1'b0;
      cor_start_r <= 1'b0;
    end else begin
      mul_start_r <= mul_go;
      div_start_r <= div_go;
      sqrt_start_r <= sqrt_go;
      cor_start_r <= cor_go;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_MIN_GAP: min_gap_r <= cfg_data;
          CFG_MAX_GAP: max_gap_r <= cfg_data;
          default: ;
        endcase
      end
      if ((state_r == S_FIN) && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            lat_r <= $signed(in_tdata[30:0]);
            lon_r <= $signed(in_tdata[62:31]);
            time_r <= in_tdata[94:63];
            fix_r <= in_tuser;
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          res_speed_r <= '0;
          res_dir_r <= '0;
          res_valid_r <= 1'b0;
          state_r <= S_FIN;
          if (fix_r) begin
            prev_lat_r <= $signed({lat_r[30], lat_r});
            prev_lon_r <= lon_r;
            prev_time_r <= time_r;
            have_prev_r <= 1'b1;
            gap_r <= gap[15:0];
            dlat_mag_r <= dlat_abs[31:0];
            dlat_neg_r <= dlat[32];
            dlon_mag_r <= dlon_abs[31:0];
            dlon_neg_r <= dlon[32];
            if (upd) begin
              cor_vec_r <= 1'b0;
              cor_x0_r <= INV_GAIN_Q30;
              cor_y0_r <= '0;
              cor_z0_r <= mean;
              state_r <= S_COS;
            end
          end
        end
        S_COS: begin
          if (cor_done) begin
            cq16_r <= cq_sum[30:14];
            mul_a_r <= {32'b0, dlat_mag_r};
            mul_b_r <= MM_PER_E7DEG;
            state_r <= S_MN;
          end
        end
        S_MN: begin
          if (mul_done) begin
            div_num_r <= mul_prod[DIV_N_W-1:0];
            div_den_r <= {1'b0, gap_r};
            state_r <= S_DN;
          end
        end
        S_DN: begin
          if (div_done) begin
            vn_r <= vel_of(div_quo, dlat_neg_r);
            mul_a_r <= {32'b0, dlon_mag_r};
            mul_b_r <= MM_PER_E7DEG;
            state_r <= S_ME1;
          end
        end
        S_ME1: begin
          if (mul_done) begin
            mul_a_r <= mul_prod;
            mul_b_r <= {16'b0, cq16_r};
            state_r <= S_ME2;
          end
        end
        S_ME2: begin
          if (mul_done) begin
            div_num_r <= mul_prod[63:16];
            div_den_r <= {1'b0, gap_r};
            state_r <= S_DE;
          end
        end
        S_DE: begin
          if (div_done) begin
            ema_e_r <= ema_e_nxt;
            ema_n_r <= ema_n_nxt;
            seeded_r <= 1'b1;
            state_r <= S_EMA;
          end
        end
        S_EMA: begin
          mul_a_r <= {32'b0, ema_e_abs};
          mul_b_r <= {1'b0, ema_e_abs};
          zero_vec_r <= (ema_e_r == 32'sd0) && (ema_n_r == 32'sd0);
          state_r <= S_SQE;
        end
        S_SQE: begin
          if (mul_done) begin
            sq_r <= mul_prod;
            mul_a_r <= {32'b0, ema_n_abs};
            mul_b_r <= {1'b0, ema_n_abs};
            state_r <= S_SQN;
          end
        end
        S_SQN: begin
          if (mul_done) begin
            sqrt_rad_r <= sq_r + mul_prod;
            state_r <= S_SQR;
          end
        end
        S_SQR: begin
          if (sqrt_done) begin
            div_num_r <= {16'b0, sqrt_root} + SPD_RND;
            div_den_r <= SPD_DIV;
            state_r <= S_CM;
          end
        end
        S_CM: begin
          if (div_done) begin
            res_speed_r <= (div_quo > SPD_MAX) ? 16'hffff : div_quo[15:0];
            if (zero_vec_r) begin
              bear_r <= '0;
              state_r <= S_WST;
            end else begin
              cor_vec_r <= 1'b1;
              cor_x0_r <= ema_n_r[31] ? -vx0 : vx0;
              cor_y0_r <= ema_n_r[31] ? -vy0 : vy0;
              cor_z0_r <= ema_n_r[31] ? DEG180_E7 : 34'sd0;
              state_r <= S_BRG;
            end
          end
        end
        S_BRG: begin
          if (cor_done) begin
            bear_r <= cor_z;
            state_r <= S_WST;
          end
        end
        S_WST: begin
          div_num_r <= {16'b0, wmod[31:0]} + DIR_RND;
          div_den_r <= DIR_DIV;
          state_r <= S_WD;
        end
        S_WD: begin
          if (div_done) begin
            res_dir_r <= (div_quo >= DIR_FULL) ? 16'(div_quo - DIR_FULL) : div_quo[15:0];
            res_valid_r <= 1'b1;
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_tvalid_r || out_tready) begin
            out_speed_r <= res_speed_r;
            out_dir_r <= res_dir_r;
            out_valid_r <= res_valid_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  gwve_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start_r),
    .a_in  (mul_a_r),
    .b_in  (mul_b_r),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  gwve_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .num   (div_num_r),
    .den   (div_den_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  gwve_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start_r),
    .rad   (sqrt_rad_r),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  gwve_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start_r),
    .vec   (cor_vec_r),
    .x0    (cor_x0_r),
    .y0    (cor_y0_r),
    .z0    (cor_z0_r),
    .done  (cor_done),
    .x_out (cor_x),
    .z_out (cor_z)
  );

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata = {out_dir_r, out_speed_r};
  assign out_tuser = out_valid_r;

endmodule
